// ----- sv/mktd_pkg.sv -----
// shared types, codes and reset values for the morse key timing decoder
`default_nettype none

package mktd_pkg;

  // field widths
  localparam int TIME_W    = 16;
  localparam int PAT_W     = 7;
  localparam int LEN_W     = 3;
  localparam int EV_W      = 3;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;

  // default symbol capacity, one more than the stored symbols
  localparam int DEFAULT_MAX_SYMBOLS = 8;

  // event machine codes
  localparam logic [EV_W-1:0] EV_INIT   = 3'd0;
  localparam logic [EV_W-1:0] EV_DOWN   = 3'd1;
  localparam logic [EV_W-1:0] EV_UP     = 3'd2;
  localparam logic [EV_W-1:0] EV_LETTER = 3'd3;
  localparam logic [EV_W-1:0] EV_WORD   = 3'd4;
  localparam logic [EV_W-1:0] EV_BKSP   = 3'd5;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DASH_THRESHOLD   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LETTER_GAP       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WORD_GAP         = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_BACKSPACE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_BACKSPACE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE         = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TONE_ENABLE      = 3'd6;

  // register reset values
  localparam logic [TIME_W-1:0] RST_DASH_THRESHOLD   = 16'd150;
  localparam logic [TIME_W-1:0] RST_LETTER_GAP       = 16'd400;
  localparam logic [TIME_W-1:0] RST_WORD_GAP         = 16'd1000;
  localparam logic [TIME_W-1:0] RST_FIRST_BACKSPACE  = 16'd1500;
  localparam logic [TIME_W-1:0] RST_REPEAT_BACKSPACE = 16'd300;
  localparam logic [TIME_W-1:0] RST_DEBOUNCE         = 16'd20;
  localparam logic              RST_TONE_ENABLE      = 1'b1;

  typedef struct packed {
    logic [TIME_W-1:0] dash_threshold_ms;
    logic [TIME_W-1:0] letter_gap_ms;
    logic [TIME_W-1:0] word_gap_ms;
    logic [TIME_W-1:0] first_backspace_ms;
    logic [TIME_W-1:0] repeat_backspace_ms;
    logic [TIME_W-1:0] debounce_ms;
    logic              tone_enable;
  } cfg_t;

  typedef struct packed {
    logic [EV_W-1:0]   event_state;
    logic [TIME_W-1:0] elapsed_ms;
    logic [TIME_W-1:0] holdoff_ms;
    logic [PAT_W-1:0]  symbol_bits;
    logic [LEN_W-1:0]  symbol_count;
    logic              tone_level;
  } state_t;

  typedef struct packed {
    logic             tone_on;
    logic             letter_valid;
    logic [PAT_W-1:0] letter_pattern;
    logic [LEN_W-1:0] letter_length;
    logic             space_valid;
    logic             backspace_pulse;
  } result_t;

endpackage

`default_nettype wire

// ----- sv/mktd_if.sv -----
// valid/ready channel interfaces for key samples, results and register writes
`default_nettype none

interface mktd_key_if;
  logic valid;
  logic ready;
  logic key_pressed;

  modport source (output valid, output key_pressed, input ready);
  modport sink (input valid, input key_pressed, output ready);
endinterface

interface mktd_result_if;
  logic                      valid;
  logic                      ready;
  logic                      tone_on;
  logic                      letter_valid;
  logic [mktd_pkg::PAT_W-1:0] letter_pattern;
  logic [mktd_pkg::LEN_W-1:0] letter_length;
  logic                      space_valid;
  logic                      backspace_pulse;

  modport source (output valid, output tone_on, output letter_valid, output letter_pattern,
                  output letter_length, output space_valid, output backspace_pulse,
                  input ready);
  modport sink (input valid, input tone_on, input letter_valid, input letter_pattern,
                input letter_length, input space_valid, input backspace_pulse,
                output ready);
endinterface

interface mktd_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [mktd_pkg::CFG_IDX_W-1:0] index;
  logic [mktd_pkg::CFG_DAT_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- sv/mktd_cfg_regs.sv -----
// configuration register file with write decode
`default_nettype none

module mktd_cfg_regs (
  input  logic           clk,
  input  logic           rst,
  mktd_cfg_if.sink       cfg,
  output mktd_pkg::cfg_t regs
);
  import mktd_pkg::*;

  // writes are always taken
  assign cfg.ready = 1'b1;

  // register write decode
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.dash_threshold_ms   <= RST_DASH_THRESHOLD;
      regs.letter_gap_ms       <= RST_LETTER_GAP;
      regs.word_gap_ms         <= RST_WORD_GAP;
      regs.first_backspace_ms  <= RST_FIRST_BACKSPACE;
      regs.repeat_backspace_ms <= RST_REPEAT_BACKSPACE;
      regs.debounce_ms         <= RST_DEBOUNCE;
      regs.tone_enable         <= RST_TONE_ENABLE;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_DASH_THRESHOLD:   regs.dash_threshold_ms   <= cfg.data;
        REG_LETTER_GAP:       regs.letter_gap_ms       <= cfg.data;
        REG_WORD_GAP:         regs.word_gap_ms         <= cfg.data;
        REG_FIRST_BACKSPACE:  regs.first_backspace_ms  <= cfg.data;
        REG_REPEAT_BACKSPACE: regs.repeat_backspace_ms <= cfg.data;
        REG_DEBOUNCE:         regs.debounce_ms         <= cfg.data;
        REG_TONE_ENABLE:      regs.tone_enable         <= cfg.data[0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- sv/mktd_step.sv -----
// one millisecond tick of the key event machine: next state and result
`default_nettype none

module mktd_step #(
  parameter int MAX_SYMBOLS = mktd_pkg::DEFAULT_MAX_SYMBOLS
) (
  input  logic              key_pressed,
  input  mktd_pkg::cfg_t    cfg,
  input  mktd_pkg::state_t  cur,
  output mktd_pkg::state_t  nxt,
  output mktd_pkg::result_t res
);
  import mktd_pkg::*;

  // stored symbols are capped by the pattern width
  localparam int SymCap = ((MAX_SYMBOLS - 1) < PAT_W) ? (MAX_SYMBOLS - 1) : PAT_W;

  always_comb begin
    nxt = cur;
    res = '0;

    // saturating time since last event
    if (cur.elapsed_ms != '1) begin
      nxt.elapsed_ms = cur.elapsed_ms + 1'b1;
    end

    if (cur.holdoff_ms != '0) begin
      // debounce hold-off, repeat timer restarts after it ends
      nxt.holdoff_ms = cur.holdoff_ms - 1'b1;
      if (cur.event_state == EV_BKSP) begin
        nxt.elapsed_ms = '0;
      end
    end else begin
      // key check
      if (key_pressed) begin
        if (cur.event_state == EV_DOWN) begin
          if (nxt.elapsed_ms > cfg.first_backspace_ms) begin
            nxt.tone_level  = 1'b0;
            res.backspace_pulse = 1'b1;
            nxt.holdoff_ms  = cfg.debounce_ms;
            nxt.event_state = EV_BKSP;
            nxt.elapsed_ms  = '0;
          end
        end else if (cur.event_state == EV_BKSP) begin
          if (nxt.elapsed_ms > cfg.repeat_backspace_ms) begin
            res.backspace_pulse = 1'b1;
            nxt.event_state = EV_BKSP;
            nxt.elapsed_ms  = '0;
          end
        end else begin
          nxt.tone_level  = cfg.tone_enable;
          nxt.event_state = EV_DOWN;
          nxt.elapsed_ms  = '0;
          nxt.holdoff_ms  = cfg.debounce_ms;
        end
      end else begin
        if (cur.event_state == EV_DOWN) begin
          // release closes a symbol, dropped when the letter is full
          nxt.tone_level = 1'b0;
          if (cur.symbol_count < LEN_W'(SymCap)) begin
            if (nxt.elapsed_ms >= cfg.dash_threshold_ms) begin
              nxt.symbol_bits = cur.symbol_bits | (PAT_W'(1) << cur.symbol_count);
            end
            nxt.symbol_count = LEN_W'(cur.symbol_count + 1'b1);
          end
          nxt.event_state = EV_UP;
          nxt.elapsed_ms  = '0;
          nxt.holdoff_ms  = cfg.debounce_ms;
        end else if (cur.event_state == EV_BKSP) begin
          nxt.event_state = EV_WORD;
          nxt.elapsed_ms  = '0;
          nxt.holdoff_ms  = cfg.debounce_ms;
        end
      end

      // gap check on the state left by the key check
      if (nxt.event_state == EV_UP && nxt.elapsed_ms > cfg.letter_gap_ms) begin
        res.letter_valid   = 1'b1;
        res.letter_pattern = nxt.symbol_bits;
        res.letter_length  = nxt.symbol_count;
        nxt.symbol_bits    = '0;
        nxt.symbol_count   = '0;
        nxt.event_state    = EV_LETTER;
        nxt.elapsed_ms     = '0;
      end else if (nxt.event_state == EV_LETTER && nxt.elapsed_ms > cfg.word_gap_ms) begin
        res.space_valid = 1'b1;
        nxt.event_state = EV_WORD;
        nxt.elapsed_ms  = '0;
      end
    end

    res.tone_on = nxt.tone_level;
  end

endmodule

`default_nettype wire

// ----- sv/morse_key_timing_decoder.sv -----
// top level of the morse straight-key timing decoder
//
// One key sample per millisecond tick goes in, one result comes out for
// each sample: sidetone level, a completed letter (dash/dot pattern and
// length), a word space or a backspace pulse. A request is registered on
// accept, stepped through the event machine and held in the result
// register, so a result is offered on the result port once its sample has
// passed the input and result registers, and a new sample is taken every
// cycle while the result port does not stall; the rate is set by the single
// state update per cycle between the input and result registers. Register
// writes are taken at any time and should only come while idle.
`default_nettype none

module morse_key_timing_decoder #(
  parameter int MAX_SYMBOLS = mktd_pkg::DEFAULT_MAX_SYMBOLS
) (
  input  logic          clk,
  input  logic          rst,
  mktd_key_if.sink      key_in,
  mktd_result_if.source result_out,
  mktd_cfg_if.sink      cfg
);
  import mktd_pkg::*;

  cfg_t    regs;
  state_t  st;
  state_t  st_next;
  result_t res_next;

  logic    in_valid;
  logic    in_key;
  logic    out_valid;
  result_t out_res;
  logic    advance;

  // register file
  mktd_cfg_regs u_cfg_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  // event machine step
  mktd_step #(
    .MAX_SYMBOLS (MAX_SYMBOLS)
  ) u_step (
    .key_pressed (in_key),
    .cfg         (regs),
    .cur         (st),
    .nxt         (st_next),
    .res         (res_next)
  );

  // handshake: input stage moves when the result register is free or drains
  assign advance      = in_valid && (!out_valid || result_out.ready);
  assign key_in.ready = !in_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (key_in.ready) begin
      in_valid <= key_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (key_in.ready && key_in.valid) begin
      in_key <= key_in.key_pressed;
    end
  end

  // event machine state
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (advance) begin
      st <= st_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (result_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= res_next;
    end
  end

  // result port
  assign result_out.valid           = out_valid;
  assign result_out.tone_on         = out_res.tone_on;
  assign result_out.letter_valid    = out_res.letter_valid;
  assign result_out.letter_pattern  = out_res.letter_pattern;
  assign result_out.letter_length   = out_res.letter_length;
  assign result_out.space_valid     = out_res.space_valid;
  assign result_out.backspace_pulse = out_res.backspace_pulse;

`ifndef ASSERT_OFF
  // a completed letter always holds at least one symbol
  a_letter_nonempty: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_res.letter_valid) |-> (out_res.letter_length != '0))
    else $error("letter completed with no symbols");

  // letter and word space never come on the same tick
  a_letter_space_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_res.letter_valid && out_res.space_valid))
    else $error("letter and space on one tick");

  // a tick in debounce hold-off leaves the event state alone
  a_holdoff_freeze: assert property (@(posedge clk) disable iff (rst)
    (advance && st.holdoff_ms != '0) |=> $stable(st.event_state))
    else $error("event state moved during hold-off");

  // an empty result register never stalls the input side
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> key_in.ready)
    else $error("input stalled with result register empty");
`endif

endmodule

`default_nettype wire
